>>> rtl/core/svd_pkg.sv
// Shared constants and small tables for the stereo vibrato delay.
// No dependencies; imported by stereo_vibrato_delay_top.
`timescale 1ns / 1ps
`default_nettype none

package svd_pkg;

	localparam int SAMPLE_BITS_DEF = 24;
	localparam int CENTER_TAP_DEF  = 400;
	localparam int SWING_MAX_DEF   = 200;

	localparam int STRENGTH_W   = 4;
	localparam int STRENGTH_MAX = 10;
	localparam int PHASE_W      = 16;

	// shared multiplier operand and product widths
	localparam int MUL_IN_W = 24;
	localparam int MUL_W    = 2 * MUL_IN_W;

	localparam int SINE_HALF = 32768;
	localparam int SINE_MAX  = 32767;
	localparam int SINE_GAIN = 315;
	localparam int SINE_SHIFT = 13;
	// ceil(2^32 / 305); exact floor quotient for products below 2^24
	localparam int RECIP_305   = 14081860;
	localparam int RECIP_SHIFT = 32;
	localparam int OFF_SHIFT   = 15;

	// Phase step per item: floor(s * 65536 / 48000)
	function automatic logic [PHASE_W-1:0] lfo_inc(input logic [STRENGTH_W-1:0] s);
		logic [PHASE_W-1:0] v;
		case (s)
			4'd1:    v = PHASE_W'((1 * 65536) / 48000);
			4'd2:    v = PHASE_W'((2 * 65536) / 48000);
			4'd3:    v = PHASE_W'((3 * 65536) / 48000);
			4'd4:    v = PHASE_W'((4 * 65536) / 48000);
			4'd5:    v = PHASE_W'((5 * 65536) / 48000);
			4'd6:    v = PHASE_W'((6 * 65536) / 48000);
			4'd7:    v = PHASE_W'((7 * 65536) / 48000);
			4'd8:    v = PHASE_W'((8 * 65536) / 48000);
			4'd9:    v = PHASE_W'((9 * 65536) / 48000);
			4'd10:   v = PHASE_W'((10 * 65536) / 48000);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/stereo_vibrato_delay_top.sv
// Stereo vibrato delay: LFO-modulated read tap on a stereo delay memory.
// Depends on svd_pkg (constants, phase step table).
//
// Usage:
//   Input channel (in_valid / in_stall) carries one stereo pair per item;
//   output channel (out_valid / out_stall) returns one pair per item.
//   cfg_we / cfg_wdata write the strength register; write only while idle.
// Sequence:
//   strength nonzero: in_stall stays high from accept until the item
//   leaves ST_DONE, so no new item is taken before the last is finished.
//   The sequencer steps the LFO phase, walks one shared 24x24 multiplier
//   through the sine, scaling, reciprocal and depth products, then makes
//   the offset, one address step and one registered memory read.
//   strength zero (bypass): the item goes from accept straight to ST_DONE.
// Stalls:
//   a finished result sits in the output register while out_stall is high;
//   one further item may be accepted meanwhile and is held at its last step.
// Reset:
//   clears strength, LFO phase, write pointer and the fill flag. Memory
//   entries not yet written read as zero (tracked by the write pointer and a
//   wrap flag), so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module stereo_vibrato_delay_top #(
	parameter int SAMPLE_BITS = svd_pkg::SAMPLE_BITS_DEF,
	parameter int CENTER_TAP  = svd_pkg::CENTER_TAP_DEF,
	parameter int SWING_MAX   = svd_pkg::SWING_MAX_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [svd_pkg::STRENGTH_W-1:0]      cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [SAMPLE_BITS-1:0]       left_in,
	input  logic signed [SAMPLE_BITS-1:0]       right_in,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [SAMPLE_BITS-1:0]       left_out,
	output logic signed [SAMPLE_BITS-1:0]       right_out
);

	import svd_pkg::*;

	localparam int STORE_LEN = CENTER_TAP + SWING_MAX + 1;
	localparam int IDX_W     = $clog2(STORE_LEN);
	localparam int DEPTH_W   = $clog2(SWING_MAX + 1);
	localparam int RW        = IDX_W + 2;
	localparam int SUM_W     = IDX_W + OFF_SHIFT;

	localparam logic signed [RW-1:0] CTAP_S = RW'(CENTER_TAP);
	localparam logic signed [RW-1:0] LEN_S  = RW'(STORE_LEN);
	localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(STORE_LEN - 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PHASE,
		ST_SQ,
		ST_SCALE,
		ST_RECIP,
		ST_DEPTH,
		ST_OFFS,
		ST_ADDR,
		ST_READ,
		ST_DONE
	} state_t;

	// Swing in samples: s * SWING_MAX / 10
	function automatic logic [DEPTH_W-1:0] depth_of(input logic [STRENGTH_W-1:0] s);
		logic [DEPTH_W-1:0] v;
		case (s)
			4'd1:    v = DEPTH_W'((1 * SWING_MAX) / STRENGTH_MAX);
			4'd2:    v = DEPTH_W'((2 * SWING_MAX) / STRENGTH_MAX);
			4'd3:    v = DEPTH_W'((3 * SWING_MAX) / STRENGTH_MAX);
			4'd4:    v = DEPTH_W'((4 * SWING_MAX) / STRENGTH_MAX);
			4'd5:    v = DEPTH_W'((5 * SWING_MAX) / STRENGTH_MAX);
			4'd6:    v = DEPTH_W'((6 * SWING_MAX) / STRENGTH_MAX);
			4'd7:    v = DEPTH_W'((7 * SWING_MAX) / STRENGTH_MAX);
			4'd8:    v = DEPTH_W'((8 * SWING_MAX) / STRENGTH_MAX);
			4'd9:    v = DEPTH_W'((9 * SWING_MAX) / STRENGTH_MAX);
			4'd10:   v = DEPTH_W'(SWING_MAX);
			default: v = '0;
		endcase
		return v;
	endfunction

	state_t                   state_q;
	logic [STRENGTH_W-1:0]    strength_q;
	logic [STRENGTH_W-1:0]    s_q;
	logic                     bypass_q;
	logic [PHASE_W-1:0]       phase_q;
	logic [IDX_W-1:0]         w_q;
	logic                     wrapped_q;
	logic [SAMPLE_BITS-1:0]   l_q;
	logic [SAMPLE_BITS-1:0]   r_q;
	logic [MUL_W-1:0]         prod_q;
	logic signed [RW-1:0]     off_q;
	logic [IDX_W-1:0]         rd_q;
	logic                     hit_q;
	logic [2*SAMPLE_BITS-1:0] rdata_q;
	logic                     out_valid_q;
	logic [SAMPLE_BITS-1:0]   left_out_q;
	logic [SAMPLE_BITS-1:0]   right_out_q;

	logic [2*SAMPLE_BITS-1:0] mem [STORE_LEN];

	logic [MUL_IN_W-1:0]      mul_a;
	logic [MUL_IN_W-1:0]      mul_b;
	logic [MUL_W-1:0]         mul_p;
	logic                     neg;
	logic [PHASE_W-2:0]       p;
	logic [PHASE_W-1:0]       q_sine;
	logic [PHASE_W-2:0]       y_sat;
	logic [SUM_W-1:0]         off_sum;
	logic [IDX_W-1:0]         off_mag;
	logic signed [RW-1:0]     rd_raw;
	logic signed [RW-1:0]     rd_wrap;
	logic                     in_acc;
	logic                     out_free;

	assign neg    = phase_q[PHASE_W-1];
	assign p      = phase_q[PHASE_W-2:0];
	assign q_sine = prod_q[RECIP_SHIFT +: PHASE_W];
	assign y_sat  = (q_sine > PHASE_W'(SINE_MAX)) ? (PHASE_W-1)'(SINE_MAX)
	                                              : q_sine[PHASE_W-2:0];

	// shared multiplier: operands follow the sequencer step
	always_comb begin
		case (state_q)
			ST_SQ: begin
				mul_a = MUL_IN_W'(p);
				mul_b = MUL_IN_W'(PHASE_W'(SINE_HALF) - PHASE_W'(p));
			end
			ST_SCALE: begin
				mul_a = MUL_IN_W'(prod_q[SINE_SHIFT +: PHASE_W]);
				mul_b = MUL_IN_W'(SINE_GAIN);
			end
			ST_RECIP: begin
				mul_a = prod_q[MUL_IN_W-1:0];
				mul_b = MUL_IN_W'(RECIP_305);
			end
			ST_DEPTH: begin
				mul_a = MUL_IN_W'(y_sat);
				mul_b = MUL_IN_W'(depth_of(s_q));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

	// negative sine rounds the offset toward minus infinity
	assign off_sum = prod_q[SUM_W-1:0] + (neg ? SUM_W'(SINE_MAX) : '0);
	assign off_mag = off_sum[SUM_W-1:OFF_SHIFT];

	assign rd_raw  = $signed({2'b00, w_q}) - CTAP_S - off_q;
	always_comb begin
		if (rd_raw < 0) begin
			rd_wrap = rd_raw + LEN_S;
		end else if (rd_raw >= LEN_S) begin
			rd_wrap = rd_raw - LEN_S;
		end else begin
			rd_wrap = rd_raw;
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			strength_q  <= '0;
			s_q         <= '0;
			bypass_q    <= 1'b0;
			phase_q     <= '0;
			w_q         <= '0;
			wrapped_q   <= 1'b0;
			l_q         <= '0;
			r_q         <= '0;
			prod_q      <= '0;
			off_q       <= '0;
			rd_q        <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
			left_out_q  <= '0;
			right_out_q <= '0;
		end else begin
			if (cfg_we) begin
				strength_q <= cfg_wdata;
			end
			// a finishing item reloads the output register itself
			if (out_valid_q && !out_stall && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						l_q      <= left_in;
						r_q      <= right_in;
						bypass_q <= (strength_q == '0);
						s_q      <= (strength_q > STRENGTH_W'(STRENGTH_MAX))
						            ? STRENGTH_W'(STRENGTH_MAX) : strength_q;
						state_q  <= (strength_q == '0) ? ST_DONE : ST_PHASE;
					end
				end
				ST_PHASE: begin
					phase_q <= phase_q + lfo_inc(s_q);
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					prod_q  <= mul_p;
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					prod_q  <= mul_p;
					state_q <= ST_RECIP;
				end
				ST_RECIP: begin
					prod_q  <= mul_p;
					state_q <= ST_DEPTH;
				end
				ST_DEPTH: begin
					prod_q  <= mul_p;
					state_q <= ST_OFFS;
				end
				ST_OFFS: begin
					off_q   <= neg ? -$signed(RW'(off_mag)) : $signed(RW'(off_mag));
					state_q <= ST_ADDR;
				end
				ST_ADDR: begin
					rd_q    <= rd_wrap[IDX_W-1:0];
					state_q <= ST_READ;
				end
				ST_READ: begin
					// entries past the write pointer are unwritten until wrap and are shown as zero
					hit_q   <= wrapped_q || (rd_q <= w_q);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (bypass_q) begin
							left_out_q  <= l_q;
							right_out_q <= r_q;
						end else begin
							left_out_q  <= hit_q ? rdata_q[2*SAMPLE_BITS-1:SAMPLE_BITS] : '0;
							right_out_q <= hit_q ? rdata_q[SAMPLE_BITS-1:0] : '0;
							if (w_q == LAST_IDX) begin
								w_q       <= '0;
								wrapped_q <= 1'b1;
							end else begin
								w_q <= w_q + 1'b1;
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// delay memory: both channels side by side, one write and one read port
	always_ff @(posedge clk) begin
		if (state_q == ST_PHASE) begin
			mem[w_q] <= {l_q, r_q};
		end
		rdata_q <= mem[rd_q];
	end

	assign out_valid = out_valid_q;
	assign left_out  = left_out_q;
	assign right_out = right_out_q;

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result shown without a finished item");

	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (rd_q < IDX_W'(STORE_LEN)))
		else $error("read tap outside the delay memory");

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		w_q < IDX_W'(STORE_LEN))
		else $error("write pointer outside the delay memory");

	a_bypass_still: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (strength_q == '0)) |=> ($stable(phase_q) && $stable(w_q)))
		else $error("bypass item moved the LFO or write pointer");

endmodule

`default_nettype wire

>>> bench/tb.sv
// Self-checking bench for stereo_vibrato_delay_top: walks a short directed table, then random
// stereo items at several strengths, and scores each pair against a typed result or a predictor.
// Depends on svd_pkg (widths, delay geometry, sine constants) and the RTL top level.
`timescale 1ns / 1ps

module tb;

	localparam int SBITS     = svd_pkg::SAMPLE_BITS_DEF;
	localparam int TAP       = svd_pkg::CENTER_TAP_DEF;
	localparam int SWING     = svd_pkg::SWING_MAX_DEF;
	localparam int LINE_LEN  = TAP + SWING + 1;
	localparam int RATE_NUM  = 65536;
	localparam int RATE_DEN  = 48000;
	localparam int SETTLE    = 4;
	localparam int TAIL      = 20;
	localparam int HOLD_LEN  = 400;
	localparam int HOLD_AT   = 1000;
	localparam int N_PLAN    = 13;
	localparam int N_PHASES  = 7;

	typedef logic [SBITS-1:0] sample_t;
	typedef logic [svd_pkg::STRENGTH_W-1:0] strength_t;

	typedef struct packed {
		sample_t l;
		sample_t r;
	} stereo_pair_t;

	typedef struct packed {
		strength_t s;
		sample_t   l;
		sample_t   r;
		bit        typed;
		sample_t   el;
		sample_t   er;
	} stim_row_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      cfg_we;
	strength_t cfg_wdata;
	logic      in_valid;
	logic      in_stall;
	sample_t   left_in;
	sample_t   right_in;
	logic      out_valid;
	logic      out_stall;
	sample_t   left_out;
	sample_t   right_out;

	// predictor copy of the block state
	sample_t         line_l [LINE_LEN];
	sample_t         line_r [LINE_LEN];
	int unsigned     wr_ptr;
	logic [15:0]     lfo;
	strength_t       strength_reg;

	stereo_pair_t    pairs_due [$];
	int              errors      = 0;
	int              items_in    = 0;
	int              pairs_seen  = 0;
	int              cfg_writes  = 0;
	bit              quiet       = 1'b0;

	// rows but the last are typed: bypass echoes input; first delayed items read the cleared line
	stim_row_t directed_plan [N_PLAN] = '{
		'{4'd0,  24'h7FFFFF, 24'h800000, 1'b1, 24'h7FFFFF, 24'h800000},
		'{4'd0,  24'h800000, 24'h7FFFFF, 1'b1, 24'h800000, 24'h7FFFFF},
		'{4'd0,  24'h000000, 24'hFFFFFF, 1'b1, 24'h000000, 24'hFFFFFF},
		'{4'd0,  24'hAAAAAA, 24'h555555, 1'b1, 24'hAAAAAA, 24'h555555},
		'{4'd0,  24'h555555, 24'hAAAAAA, 1'b1, 24'h555555, 24'hAAAAAA},
		'{4'd10, 24'h7FFFFF, 24'h800000, 1'b1, 24'h000000, 24'h000000},
		'{4'd10, 24'h123456, 24'hFEDCBA, 1'b1, 24'h000000, 24'h000000},
		'{4'd10, 24'h800000, 24'h7FFFFF, 1'b1, 24'h000000, 24'h000000},
		'{4'd15, 24'hFFFFFF, 24'h000001, 1'b1, 24'h000000, 24'h000000},
		'{4'd1,  24'h000001, 24'hFFFFFE, 1'b1, 24'h000000, 24'h000000},
		'{4'd0,  24'h3C3C3C, 24'hC3C3C3, 1'b1, 24'h3C3C3C, 24'hC3C3C3},
		'{4'd5,  24'h0F0F0F, 24'hF0F0F0, 1'b1, 24'h000000, 24'h000000},
		'{4'd5,  24'h7FFFFE, 24'h800001, 1'b0, 24'h000000, 24'h000000}
	};

	// long strength-ten runs wrap the delay line and sweep the LFO deep into its first half turn
	strength_t phase_strength [N_PHASES] = '{4'd10, 4'd15, 4'd0, 4'd1, 4'd10, 4'd4, 4'd15};
	int        phase_items    [N_PHASES] = '{450, 350, 60, 60, 300, 80, 90};

	stereo_vibrato_delay_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.left_in   (left_in),
		.right_in  (right_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.left_out  (left_out),
		.right_out (right_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void predict_pair(input sample_t l, input sample_t r,
			output sample_t pl, output sample_t pr);
		int unsigned s;
		int unsigned inc;
		int unsigned depth;
		int unsigned p;
		int unsigned num;
		int unsigned y;
		bit          neg;
		int          sine;
		longint      prod;
		longint      off;
		longint      rd;
		if (strength_reg == 0) begin
			pl = l;
			pr = r;
			return;
		end
		s = (strength_reg > svd_pkg::STRENGTH_MAX) ? svd_pkg::STRENGTH_MAX : strength_reg;
		inc = (s * RATE_NUM) / RATE_DEN;
		depth = (s * SWING) / 10;
		lfo = lfo + 16'(inc);
		p = lfo;
		neg = 1'b0;
		if (p >= svd_pkg::SINE_HALF) begin
			p = p - svd_pkg::SINE_HALF;
			neg = 1'b1;
		end
		num = p * (svd_pkg::SINE_HALF - p);
		y = ((num >> svd_pkg::SINE_SHIFT) * svd_pkg::SINE_GAIN) / 305;
		if (y > svd_pkg::SINE_MAX)
			y = svd_pkg::SINE_MAX;
		sine = neg ? -int'(y) : int'(y);
		prod = longint'(sine) * longint'(depth);
		off = prod >>> svd_pkg::OFF_SHIFT;   // floor, also for negative products
		rd = (longint'(wr_ptr) - TAP - off) % LINE_LEN;
		if (rd < 0)
			rd = rd + LINE_LEN;
		line_l[wr_ptr] = l;
		line_r[wr_ptr] = r;
		pl = line_l[int'(rd)];
		pr = line_r[int'(rd)];
		wr_ptr = (wr_ptr == LINE_LEN - 1) ? 0 : wr_ptr + 1;
	endfunction

	function automatic sample_t pick_sample();
		case ($urandom_range(7))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'h000000;
			3: return 24'hFFFFFF;
			default: return sample_t'($urandom);
		endcase
	endfunction

	// changes strength while drained, then offers one item and books its expected pair
	task automatic feed_pair(input strength_t s, input sample_t l, input sample_t r,
			input bit typed, input sample_t el, input sample_t er);
		stereo_pair_t p;
		if (s != strength_reg) begin
			in_valid <= 1'b0;
			while (pairs_due.size() != 0)
				@(posedge clk);
			repeat (SETTLE) @(posedge clk);
			cfg_we <= 1'b1;
			cfg_wdata <= s;
			@(posedge clk);
			cfg_we <= 1'b0;
			strength_reg = s;
			cfg_writes++;
		end
		while (!quiet && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		left_in <= l;
		right_in <= r;
		do
			@(posedge clk);
		while (in_stall);
		predict_pair(l, r, p.l, p.r);
		if (typed) begin
			p.l = el;
			p.r = er;
		end
		pairs_due.push_back(p);
		items_in++;
	endtask

	initial begin
		int n;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		left_in = '0;
		right_in = '0;
		for (int i = 0; i < LINE_LEN; i++) begin
			line_l[i] = '0;
			line_r[i] = '0;
		end
		wr_ptr = 0;
		lfo = '0;
		strength_reg = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_PLAN; i++)
			feed_pair(directed_plan[i].s, directed_plan[i].l, directed_plan[i].r,
				directed_plan[i].typed, directed_plan[i].el, directed_plan[i].er);

		n = 0;
		for (int ph = 0; ph < N_PHASES; ph++) begin
			for (int k = 0; k < phase_items[ph]; k++) begin
				quiet = (n >= 300 && n < 600);
				feed_pair(phase_strength[ph], pick_sample(), pick_sample(), 1'b0, '0, '0);
				n++;
			end
		end
		quiet = 1'b0;
		in_valid <= 1'b0;

		while (pairs_due.size() != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);

		$display("run: %0d stereo items in, %0d pairs checked, %0d strength writes",
			items_in, pairs_seen, cfg_writes);
		$display("run: strengths 0/1/4/5/10/15, LFO phase reached 0x%h", lfo);
		if (errors == 0 && pairs_due.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// output side: scores results, stalls at random, and once holds off long enough to back up
	initial begin
		int  hold;
		bit  held;
		stereo_pair_t want;
		hold = 0;
		held = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				pairs_seen++;
				if (pairs_due.size() == 0) begin
					$error("unexpected output item: left %h right %h", left_out, right_out);
					errors++;
				end else begin
					want = pairs_due.pop_front();
					if (left_out !== want.l) begin
						$error("left_out: expected %h, got %h", want.l, left_out);
						errors++;
					end
					if (right_out !== want.r) begin
						$error("right_out: expected %h, got %h", want.r, right_out);
						errors++;
					end
				end
			end
			if (!held && pairs_seen == HOLD_AT) begin
				held = 1'b1;
				hold = HOLD_LEN;
			end
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !quiet && ($urandom_range(99) < 36);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
